### hdl/json_token_structure_checker_core_macros.svh
// Assertion macros for the JSON token structure checker.
// Used by the checker module; needs clk and rst_n in the including scope.
`ifndef JSON_TOKEN_STRUCTURE_CHECKER_CORE_MACROS_SVH
`define JSON_TOKEN_STRUCTURE_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JTSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jtsc assertion failed");

// Next-cycle implication, checked outside reset.
`define JTSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jtsc assertion failed");

`endif

### hdl/jtsc_pkg.sv
// Shared types and constants of the JSON token structure checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package jtsc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 512;
    localparam int DEPTH_W = 10;
    localparam int TOKEN_W = 4;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 10'd512;

    // Token kinds
    localparam logic [TOKEN_W-1:0] T_OOPEN  = 4'd0;
    localparam logic [TOKEN_W-1:0] T_OCLOSE = 4'd1;
    localparam logic [TOKEN_W-1:0] T_AOPEN  = 4'd2;
    localparam logic [TOKEN_W-1:0] T_ACLOSE = 4'd3;
    localparam logic [TOKEN_W-1:0] T_COLON  = 4'd4;
    localparam logic [TOKEN_W-1:0] T_COMMA  = 4'd5;
    localparam logic [TOKEN_W-1:0] T_NULL   = 4'd6;
    localparam logic [TOKEN_W-1:0] T_STRING = 4'd10;
    localparam logic [TOKEN_W-1:0] T_END    = 4'd11;
    localparam logic [TOKEN_W-1:0] T_NONE   = 4'd15;

    // Expectation mask bits
    localparam int X_NAME  = 0;
    localparam int X_COLON = 1;
    localparam int X_AVAL  = 2;
    localparam int X_VAL   = 3;
    localparam int X_NOTV  = 4;
    localparam int MASK_W  = 5;

    // Result status codes
    localparam logic [1:0] ST_CONTINUE = 2'd0;
    localparam logic [1:0] ST_VALID    = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // Register indexes
    localparam logic REG_MAX_DEPTH = 1'b0;

    typedef enum logic [1:0] {
        PH_PARSE = 2'd0,
        PH_AWAIT = 2'd1,
        PH_DONE  = 2'd2,
        PH_ERR   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] token_kind;
        logic               start_document;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [DEPTH_W-1:0] depth;
        logic               string_is_key;
    } rsp_t;

    // Stack command for one accepted token
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic kind;   // 1 object, 0 array
    } stack_op_t;

endpackage

`default_nettype wire

### hdl/jtsc_stack.sv
// Container stack of the JSON token structure checker: one-bit entries in a
// synchronous memory, top entry in a register. Depends on jtsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtsc_stack #(
    parameter int STACK_DEPTH = jtsc_pkg::STACK_DEPTH_DEFAULT,
    parameter int SPW = $clog2(STACK_DEPTH + 1)
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  jtsc_pkg::stack_op_t   op,
    output logic [SPW-1:0]        sp,
    output logic                  top
);
    import jtsc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic           mem [STACK_DEPTH];
    logic [SPW-1:0] sp_reg, sp_next, base_sp, rd_ptr;
    logic           top_reg, top_next;
    logic           under_reg;   // entry just below the top, prefetched
    logic [AW-1:0]  rd_addr;

    always_comb
    begin
        base_sp  = op.clear ? '0 : sp_reg;
        sp_next  = base_sp;
        top_next = top_reg;
        if (op.push)
        begin
            sp_next  = base_sp + SPW'(1);
            top_next = op.kind;
        end
        else if (op.pop)
        begin
            sp_next  = base_sp - SPW'(1);
            top_next = under_reg;
        end
        // prefetch the entry below the next top
        rd_ptr  = sp_next - SPW'(2);
        rd_addr = rd_ptr[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (op.push)
        begin
            mem[base_sp[AW-1:0]] <= op.kind;
        end
        under_reg <= mem[rd_addr];
    end

    assign sp  = sp_reg;
    assign top = top_reg;

endmodule

`default_nettype wire

### hdl/json_token_structure_checker_core.sv
// JSON token structure checker, top level: request/result channels, APB
// register port, phase control and parse rules. Depends on jtsc_pkg, jtsc_stack.
`timescale 1ns / 1ps
`default_nettype none

// Checks that a stream of JSON token kinds forms exactly one well-formed
// document. One token request is taken per clock cycle and its result
// appears in the output register in the cycle after; a new request is taken
// whenever that register is empty or being read in the same cycle, so the
// sustained rate is one token per cycle while the receiver keeps up. That
// figure is set by the container stack: a single-port read of the stack
// memory each cycle prefetches the entry below the top, so a pop of any
// depth finds its new top ready. The stack memory is not cleared; only
// entries below the stack pointer are used, and a start_document token
// resets the pointer, mask and phase at once, so no clearing pass runs after
// reset. Status 2 is sticky until start_document. max_depth (address 0) must
// be written only while the block is idle; the block does not enforce this.
module json_token_structure_checker_core #(
    parameter int STACK_DEPTH = jtsc_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    // token requests
    input  wire                 req_valid,
    output logic                req_ready,
    input  jtsc_pkg::req_t      req_data,
    // results
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output jtsc_pkg::rsp_t      rsp_data,
    // register port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import jtsc_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = (SPW > DEPTH_W) ? SPW : DEPTH_W;

    // register port
    logic [DEPTH_W-1:0] max_depth_reg;

    // document state
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [TOKEN_W-1:0] prev_reg, prev_next;
    phase_t             phase_reg, phase_next;

    // result register
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_data_reg, rsp_data_next;

    // stack
    stack_op_t          stk_op;
    logic [SPW-1:0]     stk_sp;
    logic               stk_top;

    // parse datapath
    logic               accept;
    logic [TOKEN_W-1:0] t;
    logic [MASK_W-1:0]  m0, m;
    logic [TOKEN_W-1:0] prev0;
    logic [SPW-1:0]     sp0, sp_new;
    phase_t             ph0;
    logic               top_obj, value_open, ok, is_key, push, pop;
    logic [1:0]         status;

    jtsc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .SPW         (SPW)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stk_op),
        .sp    (stk_sp),
        .top   (stk_top)
    );

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= MAX_DEPTH_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_MAX_DEPTH))
        begin
            max_depth_reg <= pwdata[DEPTH_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_DEPTH)
        begin
            prdata = 32'(max_depth_reg);
        end
    end

    // ---------------- handshake ----------------
    // Take a request whenever the result register is free or draining.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // ---------------- parse rules ----------------
    // start_document wipes the document state before this token is judged.
    always_comb
    begin
        t       = req_data.token_kind;
        m0      = req_data.start_document ? '0 : mask_reg;
        prev0   = req_data.start_document ? T_NONE : prev_reg;
        sp0     = req_data.start_document ? '0 : stk_sp;
        ph0     = req_data.start_document ? PH_PARSE : phase_reg;
        top_obj = (sp0 != '0) && stk_top;
        value_open = (t inside {[T_NULL:T_STRING], T_OOPEN, T_AOPEN});

        ok     = 1'b1;
        m      = m0;
        sp_new = sp0;
        is_key = 1'b0;
        push   = 1'b0;
        pop    = 1'b0;

        if (t > T_STRING)
        begin
            // end, lexer error and unused codes are never legal while parsing
            ok = 1'b0;
        end
        else
        begin
            // what the mask expects next
            if (m[X_VAL])
            begin
                if (!value_open) ok = 1'b0;
                m[X_VAL] = 1'b0;
            end
            else if (m[X_AVAL])
            begin
                if (!(value_open || t == T_ACLOSE)) ok = 1'b0;
                m[X_AVAL] = 1'b0;
            end
            else if (m[X_NAME])
            begin
                if (!(t == T_OCLOSE || t == T_STRING)) ok = 1'b0;
            end
            else if (m[X_COLON])
            begin
                if (t != T_COLON) ok = 1'b0;
                m[X_COLON] = 1'b0;
            end
            else if (t == T_COLON)
            begin
                ok = 1'b0;
            end

            // a value may not follow a finished value
            if (m[X_NOTV])
            begin
                if (value_open) ok = 1'b0;
                m[X_NOTV] = 1'b0;
            end

            if (t == T_OOPEN || t == T_AOPEN)
            begin
                if ((sp0 >= SPW'(STACK_DEPTH)) || (CW'(sp0) >= CW'(max_depth_reg)))
                begin
                    ok = 1'b0;
                end
                push   = 1'b1;
                sp_new = sp0 + SPW'(1);
                if (t == T_OOPEN) m[X_NAME] = 1'b1;
                else              m[X_AVAL] = 1'b1;
            end
            else if (t == T_OCLOSE || t == T_ACLOSE)
            begin
                if ((sp0 == '0) || (prev0 == T_COMMA) || (top_obj != (t == T_OCLOSE)))
                begin
                    ok = 1'b0;
                end
                pop         = 1'b1;
                sp_new      = sp0 - SPW'(1);
                m[X_NAME]   = 1'b0;
                m[X_NOTV]   = 1'b1;
            end
            else if (t == T_COLON)
            begin
                if ((sp0 == '0) || !top_obj) ok = 1'b0;
                m[X_VAL] = 1'b1;
            end
            else if (t == T_COMMA)
            begin
                if ((sp0 == '0) || (prev0 == T_COMMA) || (prev0 == T_AOPEN)) ok = 1'b0;
                if (top_obj) m[X_NAME] = 1'b1;
                else         m[X_AVAL] = 1'b1;
            end
            else if (t == T_STRING)
            begin
                // a string where a member name is due becomes the key
                if (m[X_NAME])
                begin
                    is_key     = 1'b1;
                    m[X_NAME]  = 1'b0;
                    m[X_COLON] = 1'b1;
                end
                m[X_NOTV] = 1'b1;
            end
            else
            begin
                m[X_NOTV] = 1'b1;
            end
        end

        // drop every side effect of a rejected token
        if (!ok || ph0 != PH_PARSE)
        begin
            m      = m0;
            sp_new = sp0;
            is_key = 1'b0;
            push   = 1'b0;
            pop    = 1'b0;
        end
    end

    // ---------------- phase: next state ----------------
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (ph0)
                PH_PARSE:
                    if (!ok)
                        phase_next = PH_ERR;
                    else if (sp_new == '0)
                        phase_next = PH_AWAIT;
                    else
                        phase_next = PH_PARSE;
                PH_AWAIT, PH_DONE:
                    phase_next = (t == T_END) ? PH_DONE : PH_ERR;
                default:
                    phase_next = PH_ERR;
            endcase
        end
    end

    // ---------------- phase: outputs ----------------
    always_comb
    begin
        case (ph0)
            PH_PARSE:
                status = ok ? ST_CONTINUE : ST_ERROR;
            PH_AWAIT, PH_DONE:
                status = (t == T_END) ? ST_VALID : ST_ERROR;
            default:
                status = ST_ERROR;
        endcase
    end

    // ---------------- state update ----------------
    always_comb
    begin
        mask_next = mask_reg;
        prev_next = prev_reg;
        stk_op    = '0;
        if (accept)
        begin
            mask_next    = m;
            prev_next    = (ok && ph0 == PH_PARSE) ? t : prev0;
            stk_op.clear = req_data.start_document;
            stk_op.push  = push;
            stk_op.pop   = pop;
            stk_op.kind  = (t == T_OOPEN);
        end

        rsp_data_next = rsp_data_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next.status        = status;
            rsp_data_next.depth         = DEPTH_W'(sp_new);
            rsp_data_next.string_is_key = is_key;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            prev_reg      <= T_NONE;
            phase_reg     <= PH_PARSE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // hold the result payload until taken
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

### hdl/jtsc_checker.sv
// Port-level assertions for the JSON token structure checker, bound to the
// top level. Depends on jtsc_pkg and json_token_structure_checker_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "json_token_structure_checker_core_macros.svh"

module jtsc_checker (
    input wire             clk,
    input wire             rst_n,
    input wire             req_valid,
    input wire             req_ready,
    input jtsc_pkg::req_t  req_data,
    input wire             rsp_valid,
    input wire             rsp_ready,
    input jtsc_pkg::rsp_t  rsp_data
);
    import jtsc_pkg::*;

    // a stalled result holds
    `JTSC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    // every taken request yields a result on the next cycle
    `JTSC_ASSERT_NXT(a_req_to_rsp, req_valid && req_ready, rsp_valid)
    // a member key lies inside an open object and never ends the document
    `JTSC_ASSERT_IMP(a_key_in_obj, rsp_valid && rsp_data.string_is_key,
                     rsp_data.status == ST_CONTINUE && rsp_data.depth != '0)
    // a complete document has no open containers
    `JTSC_ASSERT_IMP(a_valid_flat, rsp_valid && rsp_data.status == ST_VALID,
                     rsp_data.depth == '0 && !rsp_data.string_is_key)

endmodule

bind json_token_structure_checker_core jtsc_checker u_jtsc_checker (.*);

`default_nettype wire

### dv/tb_json_token_structure_checker_core.sv
// Self-checking testbench for json_token_structure_checker_core: directed and
// random token streams, each result predicted and compared field by field.
// Depends on jtsc_pkg and the checker RTL; needs no other file.
`timescale 1ns / 1ps

module tb_json_token_structure_checker_core;

    import jtsc_pkg::*;

    // Token kinds that the package leaves unnamed
    localparam logic [TOKEN_W-1:0] T_TRUE   = 4'd7;
    localparam logic [TOKEN_W-1:0] T_FALSE  = 4'd8;
    localparam logic [TOKEN_W-1:0] T_NUMBER = 4'd9;
    localparam logic [TOKEN_W-1:0] T_LEXERR = 4'd12;
    localparam logic [TOKEN_W-1:0] T_UNUSED = 4'd13;

    localparam logic [2:0] ADDR_MAX_DEPTH = {REG_MAX_DEPTH, 2'b00};
    localparam int STACK_SIZE = STACK_DEPTH_DEFAULT;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // ------------------------------------------------------------------
    // Structure scoreboard: tracks the document state of the checker
    // (mask, previous token, container stack, phase) and holds the
    // results that accepted requests still owe.
    // ------------------------------------------------------------------
    class doc_status_board;
        logic [DEPTH_W-1:0] max_depth;
        logic [MASK_W-1:0]  mask;
        logic [TOKEN_W-1:0] prev_tok;
        bit                 kinds [STACK_SIZE];
        int                 sp;
        phase_t             phase;
        rsp_t               owed_results [$];
        int                 failures;
        int                 n_checked;
        int                 n_valid;
        int                 n_error;
        int                 n_keys;
        int                 deepest;

        function new();
            max_depth = MAX_DEPTH_RESET;
            failures  = 0;
            n_checked = 0;
            n_valid   = 0;
            n_error   = 0;
            n_keys    = 0;
            deepest   = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            mask     = '0;
            prev_tok = T_NONE;
            foreach (kinds[i]) kinds[i] = 1'b0;
            sp       = 0;
            phase    = PH_PARSE;
        endfunction

        // Apply one token while the top value is open; 0 means syntax error.
        function bit parse_token(logic [TOKEN_W-1:0] t, output bit key);
            logic [MASK_W-1:0] m;
            int                sp_n;
            bit                top_obj;
            bit                val_open;
            key  = 1'b0;
            m    = mask;
            sp_n = sp;
            top_obj = (sp_n > 0) ? kinds[sp_n-1] : 1'b0;
            if (t > T_STRING)
                return 1'b0;
            val_open = (t >= T_NULL) || (t == T_OOPEN) || (t == T_AOPEN);

            if (m[X_VAL])
            begin
                if (!val_open)
                    return 1'b0;
                m[X_VAL] = 1'b0;
            end
            else if (m[X_AVAL])
            begin
                if (!(val_open || t == T_ACLOSE))
                    return 1'b0;
                m[X_AVAL] = 1'b0;
            end
            else if (m[X_NAME])
            begin
                if (!(t == T_OCLOSE || t == T_STRING))
                    return 1'b0;
            end
            else if (m[X_COLON])
            begin
                if (t != T_COLON)
                    return 1'b0;
                m[X_COLON] = 1'b0;
            end
            else if (t == T_COLON)
                return 1'b0;

            if (m[X_NOTV])
            begin
                if (val_open)
                    return 1'b0;
                m[X_NOTV] = 1'b0;
            end

            case (t)
                T_OOPEN, T_AOPEN:
                begin
                    if (sp_n >= STACK_SIZE || sp_n + 1 > int'(max_depth))
                        return 1'b0;
                    kinds[sp_n] = (t == T_OOPEN);
                    sp_n++;
                    if (t == T_OOPEN)
                        m[X_NAME] = 1'b1;
                    else
                        m[X_AVAL] = 1'b1;
                end
                T_OCLOSE, T_ACLOSE:
                begin
                    if (sp_n == 0 || prev_tok == T_COMMA)
                        return 1'b0;
                    if (top_obj != (t == T_OCLOSE))
                        return 1'b0;
                    sp_n--;
                    m[X_NAME] = 1'b0;
                    m[X_NOTV] = 1'b1;
                end
                T_COLON:
                begin
                    if (sp_n == 0 || !top_obj)
                        return 1'b0;
                    m[X_VAL] = 1'b1;
                end
                T_COMMA:
                begin
                    if (sp_n == 0 || prev_tok == T_COMMA || prev_tok == T_AOPEN)
                        return 1'b0;
                    if (top_obj)
                        m[X_NAME] = 1'b1;
                    else
                        m[X_AVAL] = 1'b1;
                end
                T_STRING:
                begin
                    if (m[X_NAME])
                    begin
                        key        = 1'b1;
                        m[X_NAME]  = 1'b0;
                        m[X_COLON] = 1'b1;
                    end
                    m[X_NOTV] = 1'b1;
                end
                default:
                    m[X_NOTV] = 1'b1;
            endcase

            mask     = m;
            sp       = sp_n;
            prev_tok = t;
            if (sp_n == 0)
                phase = PH_AWAIT;
            return 1'b1;
        endfunction

        function rsp_t predict_result(req_t r);
            rsp_t res;
            bit   key;
            key = 1'b0;
            res.status = ST_CONTINUE;
            if (r.start_document)
                clear_doc();
            case (phase)
                PH_PARSE:
                begin
                    if (!parse_token(r.token_kind, key))
                    begin
                        key        = 1'b0;
                        phase      = PH_ERR;
                        res.status = ST_ERROR;
                    end
                end
                PH_AWAIT, PH_DONE:
                begin
                    if (r.token_kind == T_END)
                    begin
                        phase      = PH_DONE;
                        res.status = ST_VALID;
                    end
                    else
                    begin
                        phase      = PH_ERR;
                        res.status = ST_ERROR;
                    end
                end
                default:
                    res.status = ST_ERROR;
            endcase
            res.depth         = DEPTH_W'(sp);
            res.string_is_key = key;
            return res;
        endfunction

        // Note an accepted token request.
        function void take_token(req_t r);
            rsp_t res;
            res = predict_result(r);
            owed_results.insert(owed_results.size(), res);
        endfunction

        function void report_mismatch(string what, int want, int got);
            failures++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        // Compare an accepted result with the oldest owed one.
        function void compare_result(rsp_t got);
            rsp_t want;
            if (owed_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result: expected none, actual status %0d depth %0d key %0d",
                         $time, got.status, got.depth, got.string_is_key);
                return;
            end
            want = owed_results.pop_front();
            n_checked++;
            if (want.status == ST_VALID) n_valid++;
            if (want.status == ST_ERROR) n_error++;
            if (want.string_is_key) n_keys++;
            if (int'(want.depth) > deepest) deepest = int'(want.depth);
            if (got.status !== want.status)
                report_mismatch("status", int'(want.status), int'(got.status));
            if (got.depth !== want.depth)
                report_mismatch("depth", int'(want.depth), int'(got.depth));
            if (got.string_is_key !== want.string_is_key)
                report_mismatch("string_is_key", int'(want.string_is_key),
                                int'(got.string_is_key));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data  = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    idle_mode_t       idle_mode = IDLE_NONE;
    doc_status_board  board     = new();
    int               n_sent    = 0;
    logic [TOKEN_W-1:0] toks [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    json_token_structure_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Hard stop, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: stall at random according to the current idling mode.
    always @(posedge clk)
    begin
        case (idle_mode)
            IDLE_RECV: rsp_ready <= ($urandom_range(99) >= 61);
            IDLE_BOTH: rsp_ready <= ($urandom_range(99) >= 33);
            default:   rsp_ready <= 1'b1;
        endcase
    end

    // Monitor: check the result first, since it always belongs to an older
    // request than one accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                board.compare_result(rsp_data);
            if (req_valid && req_ready)
                board.take_token(req_data);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int sender_gap();
        int g;
        int pct;
        g   = 0;
        pct = (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 33 : 0;
        while (g < 16 && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    // Offer one token request and hold it until accepted. Valid stays high
    // into the next request when no gap is drawn.
    task automatic send_token(input logic [TOKEN_W-1:0] t, input logic start);
        req_t r;
        int   gap;
        r.token_kind     = t;
        r.start_document = start;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        n_sent++;
    endtask

    // Send the token list as one document: start_document on its first token.
    task automatic send_doc();
        foreach (toks[i])
            send_token(toks[i], i == 0);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write max_depth only with the block idle, then mirror it.
    task automatic set_max_depth(input logic [DEPTH_W-1:0] val);
        drain_results();
        repeat (4) @(posedge clk);
        apb_write(ADDR_MAX_DEPTH, 32'(val));
        board.max_depth = val;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic [TOKEN_W-1:0] any_scalar();
        return TOKEN_W'(T_NULL + $urandom_range(4));
    endfunction

    // Append one token to the document under construction.
    function automatic void add_tok(logic [TOKEN_W-1:0] t);
        toks.insert(toks.size(), t);
    endfunction

    // Append one well-formed value; nesting stops at cap.
    function automatic void emit_value(int lvl, int cap);
        int n;
        int k;
        k = (lvl >= cap) ? 2 : $urandom_range(2);
        if (k == 0)
        begin
            add_tok(T_OOPEN);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_tok(T_COMMA);
                add_tok(T_STRING);
                add_tok(T_COLON);
                emit_value(lvl + 1, cap);
            end
            add_tok(T_OCLOSE);
        end
        else if (k == 1)
        begin
            add_tok(T_AOPEN);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_tok(T_COMMA);
                emit_value(lvl + 1, cap);
            end
            add_tok(T_ACLOSE);
        end
        else
            add_tok(any_scalar());
    endfunction

    // Build a document with random content; broken ones get one or two
    // edits (replace, drop or insert a token, or lose the end).
    function automatic void build_doc(bit broken);
        int edits;
        int pos;
        toks.delete();
        emit_value(0, $urandom_range(4));
        add_tok(T_END);
        repeat ($urandom_range(2)) add_tok(T_END);
        if ($urandom_range(4) == 0)
            add_tok(TOKEN_W'($urandom_range(15)));
        if (broken)
        begin
            edits = $urandom_range(1, 2);
            repeat (edits)
            begin
                pos = $urandom_range(toks.size() - 1);
                case ($urandom_range(3))
                    0: toks[pos] = TOKEN_W'($urandom_range(15));
                    1: if (toks.size() > 1) toks.delete(pos);
                    2: toks.insert(pos, TOKEN_W'($urandom_range(15)));
                    default: while (toks.size() > 1 && toks[toks.size()-1] == T_END)
                                 toks.delete(toks.size() - 1);
                endcase
            end
        end
    endfunction

    // Random phase: mostly well-formed documents, some broken, some noise
    // with start_document at random.
    task automatic run_phase(input idle_mode_t mode, input int count);
        int base;
        int pick;
        idle_mode = mode;
        base = n_sent;
        while (n_sent - base < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                build_doc(1'b0);
                send_doc();
            end
            else if (pick < 85)
            begin
                build_doc(1'b1);
                send_doc();
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_token(TOKEN_W'($urandom_range(15)), $urandom_range(3) == 0);
            end
            // now and then hold off until the block has caught up
            if ($urandom_range(39) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: end and lexer errors as first token, unused codes,
        // sticky error, scalar top value with repeated end, trailing token
        // after acceptance, a nested document with keys, comma right after
        // an array open, mismatched close.
        toks = '{T_END};
        send_doc();
        toks = '{T_LEXERR, T_UNUSED, T_NONE};
        send_doc();
        toks = '{T_NULL, T_END, T_END, T_NUMBER};
        send_doc();
        toks = '{T_OOPEN, T_STRING, T_COLON, T_AOPEN, T_TRUE, T_COMMA, T_FALSE, T_ACLOSE,
                 T_COMMA, T_STRING, T_COLON, T_NUMBER, T_OCLOSE, T_END};
        send_doc();
        toks = '{T_AOPEN, T_COMMA};
        send_doc();
        toks = '{T_OOPEN, T_ACLOSE};
        send_doc();
        // pause once until every owed result is back
        drain_results();

        set_max_depth(10'd1);
        run_phase(IDLE_NONE, 80);
        set_max_depth(10'd3);
        run_phase(IDLE_SEND, 90);
        set_max_depth(10'd512);
        run_phase(IDLE_RECV, 90);
        set_max_depth(10'd6);
        run_phase(IDLE_BOTH, 90);

        // Full stack: with max_depth above the stack size, the open beyond
        // the last entry still fails.
        set_max_depth(10'd1023);
        idle_mode = IDLE_NONE;
        toks.delete();
        repeat (STACK_SIZE + 1) add_tok(T_AOPEN);
        send_doc();

        set_max_depth(10'd2);
        run_phase(IDLE_BOTH, 60);

        // Wind down: wait out every owed result, then idle before the final check.
        drain_results();
        idle_mode = IDLE_NONE;
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
        begin
            board.failures++;
            $display("%0t: %0d results never arrived", $time, board.pending());
        end

        $display("Ran %0d token requests over four idling modes, max_depth %s.",
                 n_sent, "512, 1, 3, 6, 1023, 2");
        $display("Checked %0d results: %0d valid documents, %0d errors, %0d member keys,",
                 board.n_checked, board.n_valid, board.n_error, board.n_keys);
        $display("and nesting reached depth %0d.", board.deepest);
        if (board.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/jtsc_pkg.sv
hdl/jtsc_stack.sv
hdl/json_token_structure_checker_core.sv
hdl/jtsc_checker.sv
dv/tb_json_token_structure_checker_core.sv
